/* rtl/core/rmv_pkg.sv */
package rmv_pkg;

    localparam int W_SAMPLE  = 32;
    localparam int W_COUNT   = 32;
    localparam int W_VAR     = 48;
    localparam int FRAC_BITS = 16;

    // sample minus mean, and its magnitude
    localparam int W_DIFF = W_SAMPLE + 1;
    // |d1| * |d2|
    localparam int W_PROD = 2 * W_DIFF;
    // (n-1) * var + p
    localparam int W_NUM  = W_COUNT + W_VAR + 1;
    localparam int W_ITER = $clog2(W_NUM + 1);
    // multiply step counter, and zero padding below the mean dividend
    localparam int W_MCNT = $clog2(W_DIFF + 1);
    localparam int W_VHI  = W_NUM - W_DIFF;

    localparam logic [W_ITER-1:0] DIV_MEAN_ITERS = W_ITER'(W_DIFF);
    localparam logic [W_ITER-1:0] DIV_VAR_ITERS  = W_ITER'(W_NUM);

    typedef struct packed {
        logic              start;
        logic [W_ITER-1:0] iters;
    } t_div_ctl;

endpackage

/* rtl/core/rmv_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// The dividend is left-aligned by the caller; after iters steps the
// quotient sits in the low iters bits of o_quotient.
module rmv_div
    import rmv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_ctl           i_ctl,
    input  logic [W_NUM-1:0]   i_dividend,
    input  logic [W_COUNT-1:0] i_divisor,
    output logic               o_done,
    output logic [W_NUM-1:0]   o_quotient
);

    logic [W_ITER-1:0]  r_cnt;
    logic               r_done;
    logic [W_COUNT-1:0] r_rem;
    logic [W_NUM-1:0]   r_dq;

    logic [W_COUNT:0]   n_trial;
    logic               n_bit;
    logic [W_COUNT-1:0] n_rem;

    always_comb begin
        n_trial = {r_rem, r_dq[W_NUM-1]};
        n_bit   = (n_trial >= {1'b0, i_divisor});
        n_rem   = n_bit ? W_COUNT'(n_trial - {1'b0, i_divisor}) : n_trial[W_COUNT-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_cnt <= i_ctl.iters;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == W_ITER'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_dq  <= i_dividend;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_dq  <= {r_dq[W_NUM-2:0], n_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dq;

endmodule

/* rtl/core/running_mean_variance.sv */
// channel   valid    stall    word
// input     i_valid  o_stall  i_sample
// output    o_valid  i_stall  o_count, o_mean, o_variance
//
// One sample at a time: o_stall is high from capture until the word commits.
// 33-step mean divide, 33-step shift-add multiply, 81-step variance divide,
// all bit serial, both divides through one shared restoring divider, plus setup states.
// Reset clears count, mean and variance to zero.
// A finished word waits in the output register while the next sample runs;
// the block holds before commit if that word is still stalled.
module running_mean_variance
    import rmv_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [W_SAMPLE-1:0] i_sample,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [W_COUNT-1:0]  o_count,
    output logic [W_SAMPLE-1:0] o_mean,
    output logic [W_VAR-1:0]    o_variance
);

    typedef enum logic [3:0] {
        S_IDLE, S_D1, S_A1, S_DIV1, S_MEAN, S_D2, S_A2, S_MUL, S_NUM, S_DIV2, S_FIN
    } t_state;

    t_state r_state;

    logic [W_COUNT-1:0]  r_count;
    logic [W_SAMPLE-1:0] r_mean;
    logic [W_VAR-1:0]    r_var;

    logic [W_SAMPLE-1:0] r_x;
    logic [W_COUNT-1:0]  r_n;
    logic [W_DIFF-1:0]   r_d;
    logic [W_DIFF-1:0]   r_a1;
    logic                r_neg;
    logic [W_DIFF-1:0]   r_step;
    logic [W_SAMPLE-1:0] r_mean_new;
    logic [W_PROD-1:0]   r_pp;
    logic [W_NUM-1:0]    r_pv;
    logic [W_MCNT-1:0]   r_mcnt;

    t_div_ctl            r_div_ctl;
    logic [W_NUM-1:0]    r_dividend;
    logic                div_done;
    logic [W_NUM-1:0]    div_q;

    logic                r_o_valid;
    logic [W_COUNT-1:0]  r_o_count;
    logic [W_SAMPLE-1:0] r_o_mean;
    logic [W_VAR-1:0]    r_o_var;

    logic [W_DIFF-1:0]   n_abs;
    logic [W_DIFF:0]     n_pp_sum;
    logic [W_VAR:0]      n_pv_sum;
    logic [W_VAR-1:0]    n_var;
    logic                n_fin;

    always_comb begin
        n_abs    = r_d[W_DIFF-1] ? (W_DIFF'(0) - r_d) : r_d;
        n_pp_sum = {1'b0, r_pp[W_PROD-1:W_DIFF]} + (r_pp[0] ? {1'b0, r_a1} : '0);
        n_pv_sum = {1'b0, r_pv[W_NUM-1:W_DIFF]} + (r_pv[0] ? {1'b0, r_var} : '0);
        n_var    = (div_q[W_NUM-1:W_VAR] != '0) ? '1 : div_q[W_VAR-1:0];
        n_fin    = (r_state == S_FIN) && (!r_o_valid || !i_stall);
    end

    rmv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (r_div_ctl),
        .i_dividend (r_dividend),
        .i_divisor  (r_n),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_mean    <= '0;
            r_var     <= '0;
            r_div_ctl <= '0;
            r_o_valid <= 1'b0;
            r_mcnt    <= '0;
        end else begin
            if (n_fin) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_x     <= i_sample;
                        r_n     <= (r_count == '1) ? r_count : r_count + 1'b1;
                        r_state <= S_D1;
                    end
                end
                S_D1: begin
                    r_d     <= {r_x[W_SAMPLE-1], r_x} - {r_mean[W_SAMPLE-1], r_mean};
                    r_state <= S_A1;
                end
                S_A1: begin
                    r_a1       <= n_abs;
                    r_neg      <= r_d[W_DIFF-1];
                    r_dividend <= {n_abs, {W_VHI{1'b0}}};
                    r_div_ctl  <= '{start: 1'b1, iters: DIV_MEAN_ITERS};
                    r_state    <= S_DIV1;
                end
                S_DIV1: begin
                    r_div_ctl.start <= 1'b0;
                    if (div_done) begin
                        r_step  <= r_neg ? (W_DIFF'(0) - div_q[W_DIFF-1:0])
                                         : div_q[W_DIFF-1:0];
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    r_mean_new <= r_mean + r_step[W_SAMPLE-1:0];
                    r_state    <= S_D2;
                end
                S_D2: begin
                    r_d     <= {r_x[W_SAMPLE-1], r_x}
                             - {r_mean_new[W_SAMPLE-1], r_mean_new};
                    r_state <= S_A2;
                end
                S_A2: begin
                    r_pp    <= {{W_DIFF{1'b0}}, n_abs};
                    r_pv    <= {{W_VAR{1'b0}}, 1'b0, r_n - 1'b1};
                    r_mcnt  <= W_MCNT'(W_DIFF);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_pp   <= {n_pp_sum, r_pp[W_DIFF-1:1]};
                    r_pv   <= {n_pv_sum, r_pv[W_DIFF-1:1]};
                    r_mcnt <= r_mcnt - 1'b1;
                    if (r_mcnt == W_MCNT'(1)) begin
                        r_state <= S_NUM;
                    end
                end
                S_NUM: begin
                    r_dividend <= r_pv + W_NUM'(r_pp >> FRAC_BITS);
                    r_div_ctl  <= '{start: 1'b1, iters: DIV_VAR_ITERS};
                    r_state    <= S_DIV2;
                end
                S_DIV2: begin
                    r_div_ctl.start <= 1'b0;
                    if (div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (n_fin) begin
                        r_count   <= r_n;
                        r_mean    <= r_mean_new;
                        r_var     <= n_var;
                        r_o_count <= r_n;
                        r_o_mean  <= r_mean_new;
                        r_o_var   <= n_var;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_o_valid;
    assign o_count    = r_o_count;
    assign o_mean     = r_o_mean;
    assign o_variance = r_o_var;

endmodule
